>>> hw/rtl/hsp_pkg.sv
package hsp_pkg;

    localparam int MAX_RES   = 4;
    localparam int RES_IDX_W = 2;
    localparam int RES_CNT_W = 3;

    typedef enum logic [3:0] {
        PH_START      = 4'd0,
        PH_NAME       = 4'd1,
        PH_COLON      = 4'd2,
        PH_COLON_CR   = 4'd3,
        PH_COLON_CRLF = 4'd4,
        PH_LWS        = 4'd5,
        PH_VALUE      = 4'd6,
        PH_VAL_CR     = 4'd7,
        PH_VAL_CRLF   = 4'd8,
        PH_FOLD       = 4'd9,
        PH_END_CR     = 4'd10,
        PH_BODY       = 4'd11,
        PH_ERROR      = 4'd12
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NAME   = 3'd0,
        KIND_VALUE  = 3'd1,
        KIND_BODY   = 3'd2,
        KIND_FEND   = 3'd3,
        KIND_STATUS = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SYNTAX  = 2'd1,
        ST_MISSING = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    localparam logic [2:0] MATCH_FULL = 3'd4;
    localparam logic [2:0] MATCH_NONE = 3'd7;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    localparam logic [7:0] SEQ_NAME [4] = '{8'h63, 8'h73, 8'h65, 8'h71};

    typedef struct packed {
        phase_t     phase;
        logic [2:0] match_step;
        logic       in_seq;
        logic       found;
        logic       bad;
        logic       nonempty;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{
        phase: PH_START, match_step: 3'd0, in_seq: 1'b0,
        found: 1'b0, bad: 1'b0, nonempty: 1'b0
    };

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        status_t     status;
        logic [31:0] cseq;
    } result_t;

    typedef result_t [MAX_RES-1:0] res_list_t;

    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= 8'd31) || (b == CH_DEL);
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        logic sep;
        case (b)
            8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c,
            8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20,
            8'h09: sep = 1'b1;
            default: sep = 1'b0;
        endcase
        return !sep && !is_ctl(b);
    endfunction

    function automatic result_t mk_res(input kind_t k, input logic [7:0] b);
        return '{kind: k, data: b, status: ST_OK, cseq: 32'd0};
    endfunction

endpackage

>>> hw/rtl/hsp_parse.sv
module hsp_parse
    import hsp_pkg::*;
#(
    parameter int SEQ_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output res_list_t            res,
    output logic [RES_CNT_W-1:0] res_cnt
);

    ctrl_t                ctrl_reg, ctrl_next;
    logic [SEQ_WIDTH-1:0] acc_reg, acc_next;

    logic [7:0]           lc;
    logic                 tok, ctl, wsp, is_dig;
    logic [2:0]           nm_next, nm_first;
    logic [SEQ_WIDTH+3:0] acc_ext, prod;
    logic                 vb_bad;
    logic [SEQ_WIDTH-1:0] vb_acc;
    logic                 do_vc, do_sn, sn_allow_cr, do_fend;
    logic [RES_CNT_W-1:0] n;
    logic [SEQ_WIDTH+31:0] cs_ext;
    status_t              st;

    assign lc  = (data_byte >= 8'h41 && data_byte <= 8'h5a) ? data_byte + 8'd32 : data_byte;
    assign tok = is_token(data_byte);
    assign ctl = is_ctl(data_byte);
    assign wsp = (data_byte == CH_SP) || (data_byte == CH_TAB);
    assign is_dig = (data_byte >= 8'h30) && (data_byte <= 8'h39);

    assign nm_next  = (ctrl_reg.match_step < MATCH_FULL
                       && lc == SEQ_NAME[ctrl_reg.match_step[1:0]])
                      ? ctrl_reg.match_step + 3'd1 : MATCH_NONE;
    assign nm_first = (lc == SEQ_NAME[0]) ? 3'd1 : MATCH_NONE;

    // times ten plus digit, top four bits flag overflow
    assign acc_ext = {4'b0, acc_reg};
    assign prod    = (acc_ext << 3) + (acc_ext << 1)
                   + {{SEQ_WIDTH{1'b0}}, data_byte[3:0]};

    always_comb
    begin
        vb_bad = ctrl_reg.bad;
        vb_acc = acc_reg;
        if (ctrl_reg.in_seq && !ctrl_reg.bad)
        begin
            if (!is_dig || prod[SEQ_WIDTH+3:SEQ_WIDTH] != 4'd0)
                vb_bad = 1'b1;
            else
                vb_acc = prod[SEQ_WIDTH-1:0];
        end
    end

    always_comb
    begin
        ctrl_next   = ctrl_reg;
        acc_next    = acc_reg;
        res         = '0;
        n           = '0;
        do_vc       = 1'b0;
        do_sn       = 1'b0;
        sn_allow_cr = 1'b1;
        do_fend     = 1'b0;
        st          = ST_OK;
        cs_ext      = '0;

        case (ctrl_reg.phase)
            PH_START:
            begin
                do_sn       = 1'b1;
                sn_allow_cr = 1'b0;
            end
            PH_NAME:
            begin
                if (tok)
                begin
                    ctrl_next.match_step = nm_next;
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_NAME, lc);
                    n = n + 3'd1;
                end
                else if (data_byte == CH_COLON)
                begin
                    ctrl_next.in_seq = (ctrl_reg.match_step == MATCH_FULL) && !ctrl_reg.found;
                    ctrl_next.found  = ctrl_reg.found || ctrl_next.in_seq;
                    ctrl_next.phase  = PH_COLON;
                end
                else
                    ctrl_next.phase = PH_ERROR;
            end
            PH_COLON:
            begin
                if (wsp)
                    ctrl_next.phase = PH_LWS;
                else if (data_byte == CH_CR)
                    ctrl_next.phase = PH_COLON_CR;
                else
                    do_vc = 1'b1;
            end
            PH_COLON_CR:
            begin
                ctrl_next.phase = (data_byte == CH_LF) ? PH_COLON_CRLF : PH_ERROR;
            end
            PH_COLON_CRLF:
            begin
                if (wsp)
                    ctrl_next.phase = PH_LWS;
                else
                begin
                    do_fend = 1'b1;
                    do_sn   = 1'b1;
                end
            end
            PH_LWS:
            begin
                do_vc = !wsp;
            end
            PH_VALUE:
            begin
                do_vc = 1'b1;
            end
            PH_VAL_CR:
            begin
                ctrl_next.phase = (data_byte == CH_LF) ? PH_VAL_CRLF : PH_ERROR;
            end
            PH_VAL_CRLF:
            begin
                if (wsp)
                begin
                    // folded line: the CRLF stays in the value, none of it is a digit
                    res[0] = mk_res(KIND_VALUE, CH_CR);
                    res[1] = mk_res(KIND_VALUE, CH_LF);
                    res[2] = mk_res(KIND_VALUE, data_byte);
                    n = 3'd3;
                    ctrl_next.nonempty = ctrl_reg.nonempty || ctrl_reg.in_seq;
                    ctrl_next.bad      = ctrl_reg.bad || ctrl_reg.in_seq;
                    ctrl_next.phase    = PH_FOLD;
                end
                else
                begin
                    do_fend = 1'b1;
                    do_sn   = 1'b1;
                end
            end
            PH_FOLD:
            begin
                if (wsp)
                begin
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_VALUE, data_byte);
                    n = n + 3'd1;
                    ctrl_next.nonempty = ctrl_reg.nonempty || ctrl_reg.in_seq;
                    ctrl_next.bad      = vb_bad;
                    acc_next           = vb_acc;
                end
                else
                    do_vc = 1'b1;
            end
            PH_END_CR:
            begin
                ctrl_next.phase = (data_byte == CH_LF) ? PH_BODY : PH_ERROR;
            end
            PH_BODY:
            begin
                res[n[RES_IDX_W-1:0]] = mk_res(KIND_BODY, data_byte);
                n = n + 3'd1;
            end
            default:
            begin
                ctrl_next.phase = PH_ERROR;
            end
        endcase

        if (do_fend)
        begin
            res[n[RES_IDX_W-1:0]] = mk_res(KIND_FEND, 8'h00);
            n = n + 3'd1;
            ctrl_next.in_seq = 1'b0;
        end

        if (do_sn)
        begin
            if (sn_allow_cr && data_byte == CH_CR)
                ctrl_next.phase = PH_END_CR;
            else if (tok)
            begin
                ctrl_next.match_step = nm_first;
                res[n[RES_IDX_W-1:0]] = mk_res(KIND_NAME, lc);
                n = n + 3'd1;
                ctrl_next.phase = PH_NAME;
            end
            else
                ctrl_next.phase = PH_ERROR;
        end

        if (do_vc)
        begin
            if (data_byte == CH_CR)
                ctrl_next.phase = PH_VAL_CR;
            else if (ctl)
                ctrl_next.phase = PH_ERROR;
            else
            begin
                res[n[RES_IDX_W-1:0]] = mk_res(KIND_VALUE, data_byte);
                n = n + 3'd1;
                ctrl_next.nonempty = ctrl_reg.nonempty || ctrl_reg.in_seq;
                ctrl_next.bad      = vb_bad;
                acc_next           = vb_acc;
                ctrl_next.phase    = PH_VALUE;
            end
        end

        if (last_byte)
        begin
            if (ctrl_next.phase == PH_VAL_CRLF || ctrl_next.phase == PH_COLON_CRLF)
            begin
                res[n[RES_IDX_W-1:0]] = mk_res(KIND_FEND, 8'h00);
                n = n + 3'd1;
                ctrl_next.phase = PH_BODY;
            end
            cs_ext = {32'd0, acc_next};
            if (ctrl_next.phase != PH_BODY)
                st = ST_SYNTAX;
            else if (!ctrl_next.found || !ctrl_next.nonempty)
                st = ST_MISSING;
            else if (ctrl_next.bad || acc_next == '0)
                st = ST_INVALID;
            else
                st = ST_OK;
            res[n[RES_IDX_W-1:0]] = '{kind: KIND_STATUS, data: 8'h00, status: st,
                                      cseq: (st == ST_OK) ? cs_ext[31:0] : 32'd0};
            n = n + 3'd1;
            ctrl_next = CTRL_RESET;
            acc_next  = '0;
        end

        res_cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= CTRL_RESET;
            acc_reg  <= '0;
        end
        else if (step_en)
        begin
            ctrl_reg <= ctrl_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

>>> hw/rtl/hsp_outq.sv
module hsp_outq
    import hsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  res_list_t            load_res,
    input  logic [RES_CNT_W-1:0] load_cnt,
    output logic                 free,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              head,
    output logic                 head_last
);

    res_list_t             buf_reg;
    logic [RES_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RES_IDX_W-1:0]  idx_reg, idx_next;
    logic                  beat;

    assign result_valid = (cnt_reg != '0);
    assign head         = buf_reg[idx_reg];
    assign head_last    = ({1'b0, idx_reg} == cnt_reg - 3'd1);
    assign beat         = result_valid && !result_stall;
    assign free         = !result_valid || (beat && head_last);

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = load_cnt;
            idx_next = '0;
        end
        else if (beat)
        begin
            if (head_last)
            begin
                cnt_next = '0;
                idx_next = '0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= load_res;
    end

endmodule

>>> hw/rtl/header_section_parser_unit.sv
// header section parser: takes message bytes after the start line and emits
// tagged name, value, body, field-end and status results
// input channel: byte_valid / byte_stall carry data_byte and last_byte, one
// byte per beat; last_byte marks the final byte of a message
// output channel: result_valid / result_stall carry kind, out_byte, status,
// cseq_value and run_last, one result per beat; run_last marks the final
// result caused by an input byte
// path: a taken byte goes through the input register, then the output buffer
// throughput: one byte per cycle while each byte gives at most one result
// and the receiver does not stall; a byte giving n results (up to four, on a
// fold or on the last byte) holds the input until the single-entry output
// buffer has sent its last result, draining one result per unstalled cycle
// reset: parse state returns to expecting the first name byte, input
// register and output buffer empty; after each status result the parser
// starts a new message by itself
// receiver stall: the current result holds; the input register keeps its
// byte and byte_stall rises until the buffer can take the next byte's results
module header_section_parser_unit
    import hsp_pkg::*;
#(
    parameter int SEQ_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  status,
    output logic [31:0] cseq_value,
    output logic        run_last
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic                 free, consume, accept;
    res_list_t            step_res;
    logic [RES_CNT_W-1:0] step_cnt;
    result_t              head;

    assign consume    = in_valid_reg && free;
    assign byte_stall = in_valid_reg && !free;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    hsp_parse #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (consume),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .res       (step_res),
        .res_cnt   (step_cnt)
    );

    hsp_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (consume),
        .load_res     (step_res),
        .load_cnt     (step_cnt),
        .free         (free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head),
        .head_last    (run_last)
    );

    assign kind       = head.kind;
    assign out_byte   = head.data;
    assign status     = head.status;
    assign cseq_value = head.cseq;

    // a result only shows up after a byte was handed to the parser
    a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(consume))
        else $error("result appeared without a parsed byte");

    // the status is always the final result of its byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_STATUS) |-> run_last)
        else $error("status result not marked last");

    // field end and status beats carry no byte
    a_marker_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_FEND || kind == KIND_STATUS)) |-> (out_byte == 8'h00))
        else $error("marker result carries a byte");

    // a decoded number goes out only with an ok status
    a_cseq_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && cseq_value != 32'd0) |-> (kind == KIND_STATUS && status == ST_OK))
        else $error("cseq value outside an ok status");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
    import hsp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 300;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [7:0] CSEQ_CHARS [4] = '{"c", "s", "e", "q"};

    typedef struct {
        kind_t       kind;
        logic [7:0]  data;
        status_t     st;
        logic [31:0] cseq;
        logic        fin;
    } parse_res_t;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        bit         hold;
    } byte_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [31:0] cseq_value;
    logic        run_last;

    header_section_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .out_byte     (out_byte),
        .status       (status),
        .cseq_value   (cseq_value),
        .run_last     (run_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser state mirrored by the predictor
    phase_t      ps = PH_START;
    logic [2:0]  match_step = 3'd0;
    logic        failed = 1'b0;
    logic        in_seq = 1'b0;
    logic        seq_found = 1'b0;
    logic        seq_bad = 1'b0;
    logic        seq_nonempty = 1'b0;
    logic [63:0] seq_acc = 64'd0;

    parse_res_t  step_res[$];
    parse_res_t  expected_results[$];
    byte_item_t  byte_queue[$];

    int          items_total = 0;
    int          messages_total = 0;
    int          bytes_taken = 0;
    int          results_seen = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    bit          in_taken = 1'b0;

    function automatic bit ctl_byte(input logic [7:0] b);
        return (b <= 8'd31) || (b == 8'd127);
    endfunction

    function automatic bit token_byte(input logic [7:0] b);
        bit sep;
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
            "=", "{", "}", " ", "\t": sep = 1'b1;
            default: sep = 1'b0;
        endcase
        return !sep && !ctl_byte(b);
    endfunction

    function automatic bit wsp_byte(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB);
    endfunction

    function automatic void clear_parse();
        ps = PH_START;
        match_step = 3'd0;
        failed = 1'b0;
        in_seq = 1'b0;
        seq_found = 1'b0;
        seq_bad = 1'b0;
        seq_nonempty = 1'b0;
        seq_acc = 64'd0;
    endfunction

    function automatic void add_res(input kind_t k, input logic [7:0] b, input status_t s,
                                    input logic [31:0] c);
        if (step_res.size() < MAX_RES)
            step_res.push_back('{k, b, s, c, 1'b0});
    endfunction

    function automatic void syntax_fail();
        failed = 1'b1;
        ps = PH_ERROR;
    endfunction

    function automatic void take_value(input logic [7:0] b);
        logic [63:0] d;
        add_res(KIND_VALUE, b, ST_OK, 32'd0);
        if (in_seq)
        begin
            seq_nonempty = 1'b1;
            if (!seq_bad)
            begin
                if (b < "0" || b > "9")
                    seq_bad = 1'b1;
                else
                begin
                    d = 64'(b - 8'd48);
                    if (seq_acc > (64'hFFFF_FFFF - d) / 10)
                        seq_bad = 1'b1;
                    else
                        seq_acc = seq_acc * 10 + d;
                end
            end
        end
    endfunction

    function automatic void value_char(input logic [7:0] b);
        if (b == CH_CR)
            ps = PH_VAL_CR;
        else if (ctl_byte(b))
            syntax_fail();
        else
        begin
            take_value(b);
            ps = PH_VALUE;
        end
    endfunction

    function automatic void take_name(input logic [7:0] b);
        logic [7:0] lc;
        lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (match_step < MATCH_FULL && lc == CSEQ_CHARS[match_step])
            match_step = match_step + 3'd1;
        else
            match_step = MATCH_NONE;
        add_res(KIND_NAME, lc, ST_OK, 32'd0);
        ps = PH_NAME;
    endfunction

    function automatic void open_name(input logic [7:0] b, input bit allow_cr);
        if (allow_cr && b == CH_CR)
            ps = PH_END_CR;
        else if (token_byte(b))
        begin
            match_step = 3'd0;
            take_name(b);
        end
        else
            syntax_fail();
    endfunction

    function automatic void close_field();
        add_res(KIND_FEND, 8'h00, ST_OK, 32'd0);
        in_seq = 1'b0;
    endfunction

    // works out the results of one accepted beat and queues them
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        status_t     st;
        logic [31:0] cs;
        step_res.delete();
        case (ps)
            PH_START: open_name(b, 1'b0);
            PH_NAME:
            begin
                if (token_byte(b))
                    take_name(b);
                else if (b == CH_COLON)
                begin
                    in_seq = (match_step == MATCH_FULL) && !seq_found;
                    if (in_seq)
                        seq_found = 1'b1;
                    ps = PH_COLON;
                end
                else
                    syntax_fail();
            end
            PH_COLON:
            begin
                if (wsp_byte(b))
                    ps = PH_LWS;
                else if (b == CH_CR)
                    ps = PH_COLON_CR;
                else
                    value_char(b);
            end
            PH_COLON_CR:
            begin
                if (b == CH_LF)
                    ps = PH_COLON_CRLF;
                else
                    syntax_fail();
            end
            PH_COLON_CRLF:
            begin
                if (wsp_byte(b))
                    ps = PH_LWS;
                else
                begin
                    close_field();
                    open_name(b, 1'b1);
                end
            end
            PH_LWS:
            begin
                if (!wsp_byte(b))
                    value_char(b);
            end
            PH_VALUE: value_char(b);
            PH_VAL_CR:
            begin
                if (b == CH_LF)
                    ps = PH_VAL_CRLF;
                else
                    syntax_fail();
            end
            PH_VAL_CRLF:
            begin
                // folded line: the crlf and the whitespace stay in the value
                if (wsp_byte(b))
                begin
                    take_value(CH_CR);
                    take_value(CH_LF);
                    take_value(b);
                    ps = PH_FOLD;
                end
                else
                begin
                    close_field();
                    open_name(b, 1'b1);
                end
            end
            PH_FOLD:
            begin
                if (wsp_byte(b))
                    take_value(b);
                else
                    value_char(b);
            end
            PH_END_CR:
            begin
                if (b == CH_LF)
                    ps = PH_BODY;
                else
                    syntax_fail();
            end
            PH_BODY: add_res(KIND_BODY, b, ST_OK, 32'd0);
            default: ps = PH_ERROR;
        endcase

        if (last)
        begin
            cs = 32'd0;
            if (ps == PH_VAL_CRLF || ps == PH_COLON_CRLF)
            begin
                close_field();
                ps = PH_BODY;
            end
            if (ps != PH_BODY)
                failed = 1'b1;
            if (failed)
                st = ST_SYNTAX;
            else if (!seq_found || !seq_nonempty)
                st = ST_MISSING;
            else if (seq_bad || seq_acc == 64'd0)
                st = ST_INVALID;
            else
            begin
                st = ST_OK;
                cs = seq_acc[31:0];
            end
            add_res(KIND_STATUS, 8'h00, st, cs);
            clear_parse();
        end

        if (step_res.size() > 0)
            step_res[$].fin = 1'b1;
        foreach (step_res[i])
            expected_results.push_back(step_res[i]);
    endfunction

    // stimulus construction

    function automatic logic [7:0] rand_token();
        logic [7:0] c;
        if ($urandom_range(0, 1))
        begin
            c = 8'("a" + $urandom_range(0, 25));
            if ($urandom_range(0, 1))
                c = c - 8'd32;
            return c;
        end
        do
            c = 8'($urandom_range(0, 255));
        while (!token_byte(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_value_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (ctl_byte(c));
        return c;
    endfunction

    task automatic queue_message(input logic [7:0] msg[$], input bit hold_first);
        foreach (msg[i])
            byte_queue.push_back('{msg[i], i == msg.size() - 1, hold_first && i == 0});
        items_total += msg.size();
        messages_total++;
    endtask

    task automatic queue_text(input string s, input bit fin_crlf, input logic [7:0] tail[$]);
        logic [7:0] msg[$];
        for (int i = 0; i < s.len(); i++)
            msg.push_back(s[i]);
        if (fin_crlf)
        begin
            msg.push_back(CH_CR);
            msg.push_back(CH_LF);
        end
        foreach (tail[i])
            msg.push_back(tail[i]);
        queue_message(msg, 1'b0);
    endtask

    task automatic build_message(input bit hold_first);
        logic [7:0] msg[$];
        string      s;
        int         n_fields;
        int         len;
        int         r;
        logic [7:0] c;
        bit         is_seq;

        if ($urandom_range(0, 9) == 0)
        begin
            // pure noise, every byte value allowed
            len = $urandom_range(1, 6);
            repeat (len)
                msg.push_back(8'($urandom_range(0, 255)));
            queue_message(msg, hold_first);
            return;
        end

        n_fields = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n_fields)
        begin
            is_seq = ($urandom_range(0, 2) == 0);
            if (is_seq)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    c = CSEQ_CHARS[k];
                    if ($urandom_range(0, 1))
                        c = c - 8'd32;
                    msg.push_back(c);
                end
                if ($urandom_range(0, 9) == 0)
                    msg.push_back(rand_token());
            end
            else
            begin
                len = $urandom_range(1, 5);
                repeat (len)
                    msg.push_back(rand_token());
            end
            msg.push_back(CH_COLON);

            case ($urandom_range(0, 5))
                0: msg.push_back(CH_SP);
                1: msg.push_back(CH_TAB);
                2:
                begin
                    msg.push_back(CH_CR);
                    msg.push_back(CH_LF);
                    msg.push_back(CH_SP);
                end
                3:
                begin
                    msg.push_back(CH_CR);
                    msg.push_back(CH_LF);
                    msg.push_back(CH_TAB);
                    msg.push_back(CH_SP);
                end
                default: ;
            endcase

            if (is_seq)
            begin
                case ($urandom_range(0, 11))
                    0: s = "0";
                    1: s = "4294967295";
                    2: s = "4294967296";
                    3: s = "18446744073709551616";
                    4: s = "";
                    5: s = "1x";
                    6: s = "00042";
                    default: s = $sformatf("%0d", $urandom_range(1, 99999));
                endcase
                for (int k = 0; k < s.len(); k++)
                    msg.push_back(s[k]);
                if ($urandom_range(0, 7) == 0)
                begin
                    msg.push_back(CH_CR);
                    msg.push_back(CH_LF);
                    msg.push_back(CH_SP);
                    msg.push_back("7");
                end
            end
            else
            begin
                len = $urandom_range(0, 6);
                for (int k = 0; k < len; k++)
                begin
                    if (k > 0 && $urandom_range(0, 7) == 0)
                    begin
                        msg.push_back(CH_CR);
                        msg.push_back(CH_LF);
                        msg.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
                        if ($urandom_range(0, 1))
                            msg.push_back(CH_TAB);
                    end
                    msg.push_back(rand_value_char());
                end
            end
            msg.push_back(CH_CR);
            msg.push_back(CH_LF);
        end

        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            msg.push_back(CH_CR);
            msg.push_back(CH_LF);
            len = $urandom_range(0, 4);
            repeat (len)
                msg.push_back(8'($urandom_range(0, 255)));
        end
        else if (r == 9)
        begin
            // early end at some point inside the header section
            len = $urandom_range(1, 3);
            repeat (len)
                if (msg.size() > 1)
                    void'(msg.pop_back());
        end

        r = $urandom_range(0, 19);
        if (msg.size() > 0 && r < 3)
            msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
        else if (msg.size() > 0 && r == 3)
            msg.insert($urandom_range(0, msg.size() - 1), CH_CR);

        if (msg.size() == 0)
            msg.push_back(8'($urandom_range(0, 255)));
        queue_message(msg, hold_first);
    endtask

    // sender: one beat at a time from byte_queue, random gaps between beats

    int         gap_left = 0;
    byte_item_t cur_item;

    function automatic int pick_gap();
        int r;
        // every fourth stretch of 64 bytes runs back to back
        if (((bytes_taken >> 6) % 4) == 1)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!byte_valid || in_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    byte_valid <= 1'b0;
                end
                else if (byte_queue.size() > 0 &&
                         !(byte_queue[0].hold && expected_results.size() > 0))
                begin
                    cur_item = byte_queue.pop_front();
                    data_byte <= cur_item.b;
                    last_byte <= cur_item.fin;
                    byte_valid <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold-off once the run is under way

    int stall_left = 0;
    bit long_hold_done = 1'b0;
    int stall_pick;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && results_seen >= 40)
            begin
                long_hold_done = 1'b1;
                stall_left = 250;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                if (((cycle_count / 300) % 3) != 2)
                begin
                    stall_pick = $urandom_range(0, 99);
                    if (stall_pick >= 92)
                        stall_left = $urandom_range(6, 25);
                    else if (stall_pick >= 70)
                        stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    // monitor: predict on each input beat, check each result beat

    parse_res_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken = byte_valid && !byte_stall;
            if (in_taken)
            begin
                parse_byte(data_byte, last_byte);
                bytes_taken++;
            end
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d, out_byte %02h", kind, out_byte);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        fail_count++;
                    end
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                        fail_count++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        fail_count++;
                    end
                    if (cseq_value !== want.cseq)
                    begin
                        $error("cseq_value: expected %0d, got %0d", want.cseq, cseq_value);
                        fail_count++;
                    end
                    if (run_last !== want.fin)
                    begin
                        $error("run_last: expected %0b, got %0b", want.fin, run_last);
                        fail_count++;
                    end
                    if (want.kind == KIND_STATUS)
                        status_seen[want.st]++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results still expected",
                   cycle_count, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] none[$];
        logic [7:0] tail[$];
        int         msg_idx;

        // empty line where the first name belongs
        queue_text("", 1'b1, none);
        // mixed-case cseq accepted, data ends right after the field crlf
        queue_text("CsEq:9", 1'b1, none);
        // data ends inside a fold, four results on the last beat
        tail.push_back(CH_TAB);
        queue_text("a:b", 1'b1, tail);
        // extreme byte values: high byte as name, nul inside the value
        tail.delete();
        tail.push_back(8'h00);
        queue_text(string'({8'hff, 8'h3a}), 1'b0, tail);
        // empty value over a crlf, empty line, then a body byte
        tail.delete();
        tail.push_back(CH_CR);
        tail.push_back(CH_LF);
        tail.push_back(8'h80);
        queue_text("Z:", 1'b1, tail);

        msg_idx = 0;
        while (items_total < RANDOM_BYTES + 26)
        begin
            build_message(msg_idx % 5 == 3);
            msg_idx++;
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        wait (bytes_taken == items_total);
        wait (expected_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d bytes in %0d messages, %0d results checked",
                 items_total, messages_total, results_seen);
        $display("message status: ok %0d, syntax %0d, cseq missing %0d, cseq invalid %0d",
                 status_seen[ST_OK], status_seen[ST_SYNTAX], status_seen[ST_MISSING],
                 status_seen[ST_INVALID]);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
